FILE: rtl/tfd_pkg.sv
package tfd_pkg;

   localparam int DEF_MAX_WIDTH   = 2048;
   localparam int DEF_SAMPLE_BITS = 16;
   localparam int MAX_HEIGHT      = 4096;

   localparam int CFG_W_BITS    = 12;
   localparam int CFG_H_BITS    = 13;
   localparam int COL_OUT_BITS  = 11;
   localparam int ROW_OUT_BITS  = 12;
   localparam int CSR_IDX_BITS  = 8;
   localparam int CSR_DATA_BITS = 13;

   localparam logic [CFG_W_BITS-1:0] RST_IMAGE_WIDTH  = 12'd640;
   localparam logic [CFG_H_BITS-1:0] RST_IMAGE_HEIGHT = 13'd480;

   localparam logic [CSR_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 8'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 8'd1;

   typedef enum logic [1:0] {
      RES_ABOVE,
      RES_LEFT,
      RES_FINAL
   } res_kind_type;

   typedef struct packed {
      res_kind_type kind;
      logic         last_col;
   } calc_ctl_type;

endpackage

FILE: rtl/tfd_ram.sv
module tfd_ram #(
   parameter int DATA_BITS = 48,
   parameter int DEPTH     = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_BITS-1:0]     wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_BITS-1:0]     rd_data
);

   logic [DATA_BITS-1:0] mem [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/tfd_calc.sv
module tfd_calc #(
   parameter int SAMPLE_BITS = 16,
   parameter int COL_BITS    = 11
) (
   input  logic [3*SAMPLE_BITS-1:0]          cur_px,
   input  logic [3*SAMPLE_BITS-1:0]          above_px,
   input  logic [3*SAMPLE_BITS-1:0]          next_px,
   input  logic [3*SAMPLE_BITS-1:0]          left_px,
   input  logic [COL_BITS-1:0]               col,
   input  logic [tfd_pkg::ROW_OUT_BITS-1:0]  row,
   input  tfd_pkg::calc_ctl_type             ctl,
   output logic signed [SAMPLE_BITS+1:0]     div_x,
   output logic signed [SAMPLE_BITS+1:0]     div_y,
   output logic [tfd_pkg::COL_OUT_BITS-1:0]  pixel_col,
   output logic [tfd_pkg::ROW_OUT_BITS-1:0]  pixel_row
);
   import tfd_pkg::*;

   localparam int SB = SAMPLE_BITS;
   localparam int RB = SAMPLE_BITS + 2;

   logic signed [RB-1:0] c_xx, c_yy, c_xy;
   logic signed [RB-1:0] a_xx, a_yy, a_xy;
   logic signed [RB-1:0] n_xx, n_xy;
   logic signed [RB-1:0] l_xx, l_xy;
   logic [COL_BITS-1:0]  col_m1;

   // pixel layout: xx low, then yy, then xy
   assign c_xx = RB'($signed(cur_px[SB-1:0]));
   assign c_yy = RB'($signed(cur_px[2*SB-1:SB]));
   assign c_xy = RB'($signed(cur_px[3*SB-1:2*SB]));
   assign a_xx = RB'($signed(above_px[SB-1:0]));
   assign a_yy = RB'($signed(above_px[2*SB-1:SB]));
   assign a_xy = RB'($signed(above_px[3*SB-1:2*SB]));
   assign n_xx = RB'($signed(next_px[SB-1:0]));
   assign n_xy = RB'($signed(next_px[3*SB-1:2*SB]));
   assign l_xx = RB'($signed(left_px[SB-1:0]));
   assign l_xy = RB'($signed(left_px[3*SB-1:2*SB]));

   assign col_m1 = col - COL_BITS'(1);

   always_comb begin
      div_x     = '0;
      div_y     = '0;
      pixel_col = COL_OUT_BITS'(col);
      pixel_row = row;
      case (ctl.kind)
         RES_ABOVE: begin
            if (ctl.last_col) begin
               div_x = c_xy - a_xy;
               div_y = c_yy - a_yy;
            end else begin
               div_x = (n_xx - a_xx) + (c_xy - a_xy);
               div_y = (n_xy - a_xy) + (c_yy - a_yy);
            end
            pixel_row = row - ROW_OUT_BITS'(1);
         end
         RES_LEFT: begin
            div_x     = c_xx - l_xx;
            div_y     = c_xy - l_xy;
            pixel_col = COL_OUT_BITS'(col_m1);
         end
         RES_FINAL: begin
            div_x = '0;
            div_y = '0;
         end
         default: begin
            div_x = '0;
            div_y = '0;
         end
      endcase
   end

endmodule

FILE: rtl/tensor_field_divergence.sv
// Channel  Dir  Handshake              Payload
// req      in   req_tvalid/req_tready  tensor_xx, tensor_yy, tensor_xy
// rsp      out  rsp_tvalid/rsp_tready  div_x, div_y, pixel_col, pixel_row; tlast = last_of_run
// csr      in   csr_valid/csr_ready    csr_index, csr_data
//
// One pixel beat per cycle while no results are pending; a pixel gives 0..3 result beats
// (up to two on the last row, three on the bottom-right pixel below row 0), sent one per
// cycle from a single output register while rsp is not stalled; req waits for the last one.
// The previous row sits in a one-port-read RAM read one column ahead.
// Synchronous reset clears counters and handshake state, registers go to 640x480.
// rsp stalls back up through the pixel stage into req_tready; csr is always ready.
module tensor_field_divergence #(
   parameter int MAX_WIDTH   = tfd_pkg::DEF_MAX_WIDTH,
   parameter int SAMPLE_BITS = tfd_pkg::DEF_SAMPLE_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // req_tdata: tensor_xx, tensor_yy, tensor_xy, zero pad
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0]     req_tdata,
   // rsp_tdata: div_x, div_y, pixel_col, pixel_row, zero pad
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [((2*SAMPLE_BITS+4+tfd_pkg::COL_OUT_BITS+tfd_pkg::ROW_OUT_BITS+7)/8)*8-1:0]
                                                  rsp_tdata,
   output logic                                   rsp_tlast,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [tfd_pkg::CSR_IDX_BITS-1:0]       csr_index,
   input  logic [tfd_pkg::CSR_DATA_BITS-1:0]      csr_data
);
   import tfd_pkg::*;

   localparam int PXB      = 3 * SAMPLE_BITS;
   localparam int RB       = SAMPLE_BITS + 2;
   localparam int PAY_BITS = 2*RB + COL_OUT_BITS + ROW_OUT_BITS;
   localparam int OUT_BITS = ((PAY_BITS+7)/8)*8;
   localparam int COL_BITS = $clog2(MAX_WIDTH);
   localparam int WB       = $clog2(MAX_WIDTH + 1);
   localparam int CW       = (WB > CFG_W_BITS) ? WB : CFG_W_BITS;

   // configuration
   logic [CFG_W_BITS-1:0] cfg_w_ff, cfg_w_in;
   logic [CFG_H_BITS-1:0] cfg_h_ff, cfg_h_in;
   logic                  csr_hit;
   logic [CW-1:0]         w_eff;
   logic [CFG_H_BITS-1:0] h_eff;

   // raster counters
   logic [COL_BITS-1:0]     col_cnt_ff, col_cnt_in;
   logic [ROW_OUT_BITS-1:0] row_cnt_ff, row_cnt_in;
   logic                    last_col, last_row;

   // pixel stage
   logic                    req_acc;
   logic [PXB-1:0]          cur_ff, left_ff, above_ff;
   logic [COL_BITS-1:0]     col_ff;
   logic [ROW_OUT_BITS-1:0] row_ff;
   logic                    last_col_ff, byp_ff;
   logic [2:0]              pend_ff, pend_in, pend_new;
   logic [PXB-1:0]          ram_q, next_px;
   logic [COL_BITS-1:0]     rd_addr;
   logic                    pend_single;
   calc_ctl_type            ctl;

   // output register
   logic                        out_load;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_last_ff;
   logic signed [RB-1:0]        dx, dy;
   logic [COL_OUT_BITS-1:0]     pcol;
   logic [ROW_OUT_BITS-1:0]     prow;
   logic [PAY_BITS-1:0]         rsp_pay_ff;

   assign csr_ready = 1'b1;
   assign csr_hit   = csr_valid && (csr_index == REG_IMAGE_WIDTH ||
                                    csr_index == REG_IMAGE_HEIGHT);

   always_comb begin
      cfg_w_in = cfg_w_ff;
      cfg_h_in = cfg_h_ff;
      if (csr_valid && csr_index == REG_IMAGE_WIDTH) begin
         cfg_w_in = csr_data[CFG_W_BITS-1:0];
      end
      if (csr_valid && csr_index == REG_IMAGE_HEIGHT) begin
         cfg_h_in = csr_data[CFG_H_BITS-1:0];
      end
   end

   always_comb begin
      if (cfg_w_ff == '0) begin
         w_eff = CW'(1);
      end else if (CW'(cfg_w_ff) > CW'(MAX_WIDTH)) begin
         w_eff = CW'(MAX_WIDTH);
      end else begin
         w_eff = CW'(cfg_w_ff);
      end
      if (cfg_h_ff == '0) begin
         h_eff = CFG_H_BITS'(1);
      end else if (cfg_h_ff > CFG_H_BITS'(MAX_HEIGHT)) begin
         h_eff = CFG_H_BITS'(MAX_HEIGHT);
      end else begin
         h_eff = cfg_h_ff;
      end
   end

   assign last_col = (CW'(col_cnt_ff) + CW'(1)) == w_eff;
   assign last_row = (CFG_H_BITS'(row_cnt_ff) + CFG_H_BITS'(1)) == h_eff;

   // emitter: lowest pending bit goes out first (above, left, final)
   assign pend_single = (pend_ff & (pend_ff - 3'd1)) == 3'd0;
   assign out_load    = (pend_ff != 3'd0) && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = (pend_ff == 3'd0) || (out_load && pend_single);
   assign req_acc     = req_tvalid && req_tready;

   assign pend_new = {last_row && last_col,
                      last_row && (col_cnt_ff != '0),
                      row_cnt_ff != '0};

   always_comb begin
      pend_in = pend_ff;
      if (out_load) begin
         pend_in = pend_ff & (pend_ff - 3'd1);
      end
      if (req_acc) begin
         pend_in = pend_new;
      end
   end

   always_comb begin
      col_cnt_in = col_cnt_ff;
      row_cnt_in = row_cnt_ff;
      if (csr_hit) begin
         col_cnt_in = '0;
         row_cnt_in = '0;
      end else if (req_acc) begin
         if (last_col) begin
            col_cnt_in = '0;
            row_cnt_in = last_row ? '0 : row_cnt_ff + ROW_OUT_BITS'(1);
         end else begin
            col_cnt_in = col_cnt_ff + COL_BITS'(1);
         end
      end
   end

   // read one column ahead; at the end of a row, column 0 for the next row
   assign rd_addr = last_col ? '0 : col_cnt_ff + COL_BITS'(1);

   tfd_ram #(
      .DATA_BITS (PXB),
      .DEPTH     (MAX_WIDTH)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (req_acc),
      .wr_addr (col_cnt_ff),
      .wr_data (req_tdata[PXB-1:0]),
      .rd_en   (req_acc),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // one-pixel rows read the entry written on the same beat
   assign next_px = byp_ff ? cur_ff : ram_q;

   always_ff @(posedge clock) begin
      if (req_acc) begin
         cur_ff      <= req_tdata[PXB-1:0];
         left_ff     <= cur_ff;
         above_ff    <= next_px;
         col_ff      <= col_cnt_ff;
         row_ff      <= row_cnt_ff;
         last_col_ff <= last_col;
         byp_ff      <= last_col && (col_cnt_ff == '0);
      end
   end

   always_comb begin
      ctl.last_col = last_col_ff;
      if (pend_ff[0]) begin
         ctl.kind = RES_ABOVE;
      end else if (pend_ff[1]) begin
         ctl.kind = RES_LEFT;
      end else begin
         ctl.kind = RES_FINAL;
      end
   end

   tfd_calc #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COL_BITS    (COL_BITS)
   ) u_calc (
      .cur_px    (cur_ff),
      .above_px  (above_ff),
      .next_px   (next_px),
      .left_px   (left_ff),
      .col       (col_ff),
      .row       (row_ff),
      .ctl       (ctl),
      .div_x     (dx),
      .div_y     (dy),
      .pixel_col (pcol),
      .pixel_row (prow)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_pay_ff  <= {prow, pcol, dy, dx};
         rsp_last_ff <= pend_single;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_w_ff     <= RST_IMAGE_WIDTH;
         cfg_h_ff     <= RST_IMAGE_HEIGHT;
         col_cnt_ff   <= '0;
         row_cnt_ff   <= '0;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_w_ff     <= cfg_w_in;
         cfg_h_ff     <= cfg_h_in;
         col_cnt_ff   <= col_cnt_in;
         row_cnt_ff   <= row_cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = OUT_BITS'(rsp_pay_ff);

`ifndef SYNTH
   // a new pixel only enters once the previous one sends its final result
   a_no_drop : assert property (@(posedge clock) disable iff (reset)
      (req_acc && pend_ff != 3'd0) |-> (out_load && pend_single))
      else $error("pixel accepted with results still pending");

   // any pixel below the first row owes a result for the row above
   a_above_owed : assert property (@(posedge clock) disable iff (reset)
      (req_acc && row_cnt_ff != '0 && !csr_hit) |=> pend_ff[0])
      else $error("row-above result not scheduled");

   a_load_shows : assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_valid_ff)
      else $error("loaded result not presented");
`endif

endmodule
